// ----- hdl/stop_codon_frame_scanner_macros.svh -----
// ---------------------------------------------------------------------------
// Stop codon frame scanner assertion macros
// Shared assertion wrappers for the checker of the stop codon frame scanner.
// ---------------------------------------------------------------------------
`ifndef STOP_CODON_FRAME_SCANNER_MACROS_SVH
`define STOP_CODON_FRAME_SCANNER_MACROS_SVH

// Checked on every rising edge outside reset.
`define SCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SCFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/scfs_pkg.sv -----
// ---------------------------------------------------------------------------
// Stop codon frame scanner package
// Types, codes, the automaton transition table and the base decoder.
// ---------------------------------------------------------------------------
package scfs_pkg;

  localparam int CharWidth  = 8;
  localparam int StateWidth = 4;
  localparam int PhaseWidth = 2;
  localparam int FlagWidth  = 6;
  localparam int NumStates  = 10;

  // Base codes produced by the decoder.
  localparam logic [2:0] BASE_A   = 3'd0;
  localparam logic [2:0] BASE_C   = 3'd1;
  localparam logic [2:0] BASE_G   = 3'd2;
  localparam logic [2:0] BASE_T   = 3'd3;
  localparam logic [2:0] BASE_BAD = 3'd4;

  // ASCII codes of the accepted characters.
  localparam logic [CharWidth-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CharWidth-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CharWidth-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CharWidth-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CharWidth-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CharWidth-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CharWidth-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CharWidth-1:0] CHAR_T_LO = 8'h74;

  // Automaton states with a meaning of their own.
  localparam logic [StateWidth-1:0] ST_IDLE     = 4'd0;
  localparam logic [StateWidth-1:0] ST_LAST     = 4'd9;
  localparam logic [StateWidth-1:0] ST_FWD_STOP = 4'd7;

  localparam logic [PhaseWidth-1:0] PHASE_RESET = 2'd1;
  localparam logic [PhaseWidth-1:0] PHASE_TOP   = 2'd2;

  // Next state for each state and each base, columns in the order a, c, g, t.
  localparam logic [StateWidth-1:0] NEXT_TAB [NumStates][4] = '{
    '{4'd0, 4'd2, 4'd0, 4'd1},
    '{4'd3, 4'd4, 4'd5, 4'd6},
    '{4'd0, 4'd2, 4'd0, 4'd6},
    '{4'd7, 4'd2, 4'd7, 4'd1},
    '{4'd8, 4'd2, 4'd0, 4'd6},
    '{4'd7, 4'd2, 4'd0, 4'd1},
    '{4'd9, 4'd4, 4'd5, 4'd6},
    '{4'd0, 4'd2, 4'd0, 4'd1},
    '{4'd0, 4'd2, 4'd0, 4'd1},
    '{4'd7, 4'd2, 4'd7, 4'd1}
  };

  typedef struct packed {
    logic [StateWidth-1:0] scan_state;
    logic [PhaseWidth-1:0] frame_phase;
    logic [FlagWidth-1:0]  hit_flags;
  } scan_ctx_t;

  typedef struct packed {
    scan_ctx_t ctx;
    logic      bad;
  } step_res_t;

  localparam scan_ctx_t CTX_RESET = '{
    scan_state:  ST_IDLE,
    frame_phase: PHASE_RESET,
    hit_flags:   '0
  };

  function automatic logic [2:0] base_code(input logic [CharWidth-1:0] ch);
    logic [2:0] code;
    case (ch) inside
      CHAR_A_UP, CHAR_A_LO: code = BASE_A;
      CHAR_C_UP, CHAR_C_LO: code = BASE_C;
      CHAR_G_UP, CHAR_G_LO: code = BASE_G;
      CHAR_T_UP, CHAR_T_LO: code = BASE_T;
      default:              code = BASE_BAD;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/stop_codon_frame_scanner.sv -----
// A word accepted into the input register moves into the result register once the result side can take it.
// Throughput: one word per cycle, sustained, while the result side is not stalled.
// The scan context is a single register loop through one table lookup, so the rate is one.
// Reset (rst, synchronous, active high) empties both stages and restores state 0, phase 1
// and clear flags; a word marked last restores the same context for the next sequence.
// ---------------------------------------------------------------------------
// Stop codon frame scanner
// Six-frame stop codon detector over a stream of nucleotide characters.
// ---------------------------------------------------------------------------
module stop_codon_frame_scanner import scfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input word channel.
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [CharWidth-1:0] base_char,
  input  logic                 is_last,
  // Result word channel.
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [FlagWidth-1:0] stop_flags,
  output logic                 bad_char,
  output logic                 seq_end
);

  // The design is two registered stages. The input register captures each
  // accepted word. Between it and the result register sits the step logic,
  // which decodes the character, looks up the next automaton state and
  // updates the sticky flags. The scan context is committed at the same edge
  // at which the word moves into the result register, so the context always
  // reflects exactly the words that have reached the result side.

  logic                 s1_valid;
  logic [CharWidth-1:0] s1_char;
  logic                 s1_last;
  scan_ctx_t            ctx;
  step_res_t            res;
  logic                 adv;
  logic                 move;

  scfs_step u_step (
    .base_char (s1_char),
    .ctx       (ctx),
    .res       (res)
  );

  // The result register can take a new word when it is empty or its word is
  // being taken in this cycle.
  assign adv  = !result_valid || !result_stall;
  assign move = s1_valid && adv;

  // The input register accepts a word whenever it is empty or its own word
  // moves on, so a waiting result blocks the input only once the input
  // register is full as well.
  assign item_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      ctx          <= CTX_RESET;
    end else begin
      if (item_valid && !item_stall) begin
        s1_valid <= 1'b1;
        s1_char  <= base_char;
        s1_last  <= is_last;
      end else if (move) begin
        s1_valid <= 1'b0;
      end

      if (move) begin
        result_valid <= 1'b1;
        stop_flags   <= res.ctx.hit_flags;
        bad_char     <= res.bad;
        seq_end      <= s1_last;
        // The last word of a sequence hands back a clean context.
        ctx          <= s1_last ? CTX_RESET : res.ctx;
      end else if (adv) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/scfs_step.sv -----
// ---------------------------------------------------------------------------
// Stop codon frame scanner step logic
// Decodes one character and advances the automaton, phase and sticky flags.
// ---------------------------------------------------------------------------
module scfs_step import scfs_pkg::*; (
  input  logic [CharWidth-1:0] base_char,
  input  scan_ctx_t            ctx,
  output step_res_t            res
);

  logic [2:0]            code;
  logic [StateWidth-1:0] st;
  logic [StateWidth-1:0] st_next;
  logic [PhaseWidth-1:0] ph;
  logic [FlagWidth-1:0]  flags_next;

  always_comb begin
    code = base_code(base_char);

    // States above the table and the unused phase code fall back to zero.
    st = (ctx.scan_state > ST_LAST) ? ST_IDLE : ctx.scan_state;
    ph = (ctx.frame_phase > PHASE_TOP) ? '0 : ctx.frame_phase;

    if (code == BASE_BAD) begin
      st_next = ST_IDLE;
    end else begin
      st_next = NEXT_TAB[st][code[1:0]];
    end

    flags_next = ctx.hit_flags;
    if (st_next == ST_FWD_STOP) begin
      flags_next = ctx.hit_flags | (FlagWidth'(1) << ph);
    end else if (st_next > ST_FWD_STOP) begin
      flags_next = ctx.hit_flags | (FlagWidth'(8) << ph);
    end

    res.ctx.scan_state  = st_next;
    res.ctx.frame_phase = (ph == PHASE_TOP) ? '0 : ph + PhaseWidth'(1);
    res.ctx.hit_flags   = flags_next;
    res.bad             = (code == BASE_BAD);
  end

endmodule

// ----- hdl/scfs_checker.sv -----
// ---------------------------------------------------------------------------
// Stop codon frame scanner checker
// Port-level assertions on the scanner, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "stop_codon_frame_scanner_macros.svh"

module scfs_checker import scfs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input logic [CharWidth-1:0] base_char,
  input logic                 is_last,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic [FlagWidth-1:0] stop_flags,
  input logic                 bad_char,
  input logic                 seq_end
);

  // The input side only stalls when a full result register is held back.
  `SCFS_ASSERT(a_stall_cause, item_stall |-> result_valid && result_stall, "input stall without result stall")

  // A held result keeps its word.
  `SCFS_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable({stop_flags, bad_char, seq_end}), "stalled result changed")

  // A cycle in reset leaves both stages empty.
  `SCFS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid && !item_stall, "stage not empty after reset")

endmodule

bind stop_codon_frame_scanner scfs_checker u_scfs_checker (.*);
